// ----- rtl/scfp_pkg.sv -----
package scfp_pkg;

    localparam int WORD_W    = 16;
    localparam int OUT_WORDS = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [7:0]        t_char;

    localparam t_char CHAR_NUL   = 8'd0;
    localparam t_char CHAR_STAR  = 8'd42;
    localparam t_char CHAR_PLUS  = 8'd43;
    localparam t_char CHAR_COMMA = 8'd44;
    localparam t_char CHAR_MINUS = 8'd45;
    localparam t_char CHAR_ZERO  = 8'd48;
    localparam t_char CHAR_NINE  = 8'd57;
    localparam t_char CHAR_TAB   = 8'd9;
    localparam t_char CHAR_CR    = 8'd13;
    localparam t_char CHAR_SPACE = 8'd32;

    typedef logic [1:0] t_phase;

    localparam t_phase PH_IDLE  = 2'd0;
    localparam t_phase PH_SPACE = 2'd1;
    localparam t_phase PH_NUM   = 2'd2;
    localparam t_phase PH_END   = 2'd3;

    function automatic logic is_space(input t_char c);
        return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    endfunction

    function automatic logic is_digit(input t_char c);
        return c inside {[CHAR_ZERO:CHAR_NINE]};
    endfunction

endpackage

// ----- rtl/serial_command_field_parser.sv -----
// Parses text commands from a byte stream. Each byte is one transfer on the input channel;
// a '*' ends the command and produces exactly one transfer on the output channel carrying
// the three command words and an updated flag, while other bytes produce none. Comma
// separated decimal fields load the words in order, a text without a comma loads word 0
// and clears the others, and an empty command leaves the words as they were with the
// flag low. One byte is taken per clock cycle unless a '*' waits on an untaken result;
// an input register feeds a single pass of parse logic, and a separate result register
// lets bytes keep flowing while a result waits to be taken; a '*' passes both in order.
module serial_command_field_parser #(
    parameter int MAX_CHARS = 31,
    parameter int NUM_WORDS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_word_zero,
    output logic signed [15:0]  o_word_one,
    output logic signed [15:0]  o_word_two,
    output logic                o_updated
);
    import scfp_pkg::*;

    localparam int POS_W = $clog2(MAX_CHARS + 1);
    localparam int IDX_W = $clog2(NUM_WORDS + 1);

    logic                              r_in_valid;
    t_char                             r_in_char;
    logic [POS_W-1:0]                  r_pos,      n_pos;
    logic                              r_comma,    n_comma;
    logic [IDX_W-1:0]                  r_idx,      n_idx;
    t_phase                            r_phase,    n_phase;
    logic                              r_neg,      n_neg;
    logic [NUM_WORDS-1:0][WORD_W-1:0]  r_pend,     n_pend;
    logic [NUM_WORDS-1:0]              r_pend_vld, n_pend_vld;
    logic [NUM_WORDS-1:0][WORD_W-1:0]  r_cmd,      n_cmd;
    logic                              n_updated;
    logic                              r_out_valid;
    t_word                             r_out_word [OUT_WORDS];
    logic                              r_out_updated;
    logic                              out_free;
    logic                              is_star;
    logic                              step_go;

    assign out_free = !r_out_valid || i_ready;
    assign is_star  = (r_in_char == CHAR_STAR);
    assign step_go  = r_in_valid && (!is_star || out_free);
    assign o_ready  = !r_in_valid || step_go;

    scfp_step #(
        .MAX_CHARS (MAX_CHARS),
        .NUM_WORDS (NUM_WORDS),
        .POS_W     (POS_W),
        .IDX_W     (IDX_W)
    ) u_step (
        .i_char     (r_in_char),
        .i_pos      (r_pos),
        .i_comma    (r_comma),
        .i_idx      (r_idx),
        .i_phase    (r_phase),
        .i_neg      (r_neg),
        .i_pend     (r_pend),
        .i_pend_vld (r_pend_vld),
        .i_cmd      (r_cmd),
        .o_pos      (n_pos),
        .o_comma    (n_comma),
        .o_idx      (n_idx),
        .o_phase    (n_phase),
        .o_neg      (n_neg),
        .o_pend     (n_pend),
        .o_pend_vld (n_pend_vld),
        .o_cmd      (n_cmd),
        .o_updated  (n_updated)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_char <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_comma    <= 1'b0;
            r_idx      <= '0;
            r_phase    <= PH_IDLE;
            r_neg      <= 1'b0;
            r_pend     <= '0;
            r_pend_vld <= '0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_cmd[k] <= (k == 0) ? t_word'(1) : '0;
            end
        end else if (step_go) begin
            r_pos      <= n_pos;
            r_comma    <= n_comma;
            r_idx      <= n_idx;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
            r_cmd      <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step_go && is_star;
        end
        if (step_go && is_star) begin
            r_out_updated <= n_updated;
            for (int j = 0; j < OUT_WORDS; j++) begin
                r_out_word[j] <= (j < NUM_WORDS) ? n_cmd[(j < NUM_WORDS) ? j : 0] : '0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_word_zero = $signed(r_out_word[0]);
    assign o_word_one  = $signed(r_out_word[1]);
    assign o_word_two  = $signed(r_out_word[2]);
    assign o_updated   = r_out_updated;

endmodule

// ----- rtl/scfp_step.sv -----
module scfp_step #(
    parameter int MAX_CHARS = 31,
    parameter int NUM_WORDS = 3,
    parameter int POS_W     = 5,
    parameter int IDX_W     = 2
) (
    input  scfp_pkg::t_char                        i_char,
    input  logic [POS_W-1:0]                       i_pos,
    input  logic                                   i_comma,
    input  logic [IDX_W-1:0]                       i_idx,
    input  scfp_pkg::t_phase                       i_phase,
    input  logic                                   i_neg,
    input  logic [NUM_WORDS-1:0][scfp_pkg::WORD_W-1:0] i_pend,
    input  logic [NUM_WORDS-1:0]                   i_pend_vld,
    input  logic [NUM_WORDS-1:0][scfp_pkg::WORD_W-1:0] i_cmd,
    output logic [POS_W-1:0]                       o_pos,
    output logic                                   o_comma,
    output logic [IDX_W-1:0]                       o_idx,
    output scfp_pkg::t_phase                       o_phase,
    output logic                                   o_neg,
    output logic [NUM_WORDS-1:0][scfp_pkg::WORD_W-1:0] o_pend,
    output logic [NUM_WORDS-1:0]                   o_pend_vld,
    output logic [NUM_WORDS-1:0][scfp_pkg::WORD_W-1:0] o_cmd,
    output logic                                   o_updated
);
    import scfp_pkg::*;

    logic  ws;
    logic  counts;
    t_word digit;
    t_word fin_word [NUM_WORDS];
    logic  fin_vld  [NUM_WORDS];

    assign ws    = is_space(i_char);
    assign digit = t_word'(i_char - CHAR_ZERO);

    always_comb begin
        o_pos      = i_pos;
        o_comma    = i_comma;
        o_idx      = i_idx;
        o_phase    = i_phase;
        o_neg      = i_neg;
        o_pend     = i_pend;
        o_pend_vld = i_pend_vld;
        o_cmd      = i_cmd;
        o_updated  = 1'b0;
        counts     = 1'b0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            fin_word[k] = i_pend[k];
            fin_vld[k]  = i_pend_vld[k];
        end

        if (i_char == CHAR_STAR) begin
            counts = (i_phase == PH_NUM) || (i_phase == PH_END);
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (counts && (i_idx == IDX_W'(k))) begin
                    fin_vld[k] = 1'b1;
                    if (i_neg) begin
                        fin_word[k] = t_word'(0) - i_pend[k];
                    end
                end
            end
            if (i_pos != '0) begin
                o_updated = 1'b1;
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (i_comma) begin
                        if (fin_vld[k]) begin
                            o_cmd[k] = fin_word[k];
                        end
                    end else begin
                        o_cmd[k] = (k == 0) ? fin_word[0] : '0;
                    end
                end
            end
            o_pos      = '0;
            o_comma    = 1'b0;
            o_idx      = '0;
            o_phase    = PH_IDLE;
            o_neg      = 1'b0;
            o_pend     = '0;
            o_pend_vld = '0;
        end else if (i_char != CHAR_NUL && !(i_pos == '0 && ws)) begin
            if (i_pos < POS_W'(MAX_CHARS)) begin
                o_pos = i_pos + POS_W'(1);
                if (i_char == CHAR_COMMA) begin
                    o_comma = 1'b1;
                    counts  = (i_phase != PH_IDLE);
                    for (int k = 0; k < NUM_WORDS; k++) begin
                        if (counts && (i_idx == IDX_W'(k))) begin
                            o_pend_vld[k] = 1'b1;
                            if (i_neg) begin
                                o_pend[k] = t_word'(0) - i_pend[k];
                            end
                        end
                    end
                    if (counts) begin
                        o_idx = (i_idx < IDX_W'(NUM_WORDS)) ? i_idx + IDX_W'(1)
                                                            : IDX_W'(NUM_WORDS);
                    end
                    o_phase = PH_IDLE;
                    o_neg   = 1'b0;
                end else if (i_phase == PH_IDLE || i_phase == PH_SPACE) begin
                    if (ws) begin
                        o_phase = PH_SPACE;
                    end else if (i_char == CHAR_PLUS || i_char == CHAR_MINUS) begin
                        o_phase = PH_NUM;
                        o_neg   = (i_char == CHAR_MINUS);
                    end else if (is_digit(i_char)) begin
                        o_phase = PH_NUM;
                        for (int k = 0; k < NUM_WORDS; k++) begin
                            if (i_idx == IDX_W'(k)) begin
                                o_pend[k] = digit;
                            end
                        end
                    end else begin
                        o_phase = PH_END;
                    end
                end else if (i_phase == PH_NUM) begin
                    if (is_digit(i_char)) begin
                        for (int k = 0; k < NUM_WORDS; k++) begin
                            if (i_idx == IDX_W'(k)) begin
                                o_pend[k] = (i_pend[k] << 3) + (i_pend[k] << 1) + digit;
                            end
                        end
                    end else begin
                        o_phase = PH_END;
                    end
                end
            end else if (!ws && i_phase == PH_SPACE) begin
                o_phase = PH_END;
            end
        end
    end

endmodule
